@@ hdl/assert_macros.svh @@
// Assertion macros shared by the gyro heading tracker RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("heading tracker check failed");

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heading tracker check failed");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heading tracker check failed");

`endif

@@ hdl/dght_pkg.sv @@
// Package: constants, widths and types of the dual gyro heading tracker
package dght_pkg;

  // Fixed point and angle constants
  localparam int FRAC_BITS  = 8;
  localparam int TURN       = 3600;
  localparam int HALF_TURN  = 1800;
  localparam int WRAP_LIMIT = 2500;

  // Field widths
  localparam int FUNC_W    = 2;
  localparam int SAMPLE_W  = 13;
  localparam int NH_W      = 12;
  localparam int GAIN_W    = 16;
  localparam int OUT_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

  // Heading range in Q.FRAC_BITS
  localparam int TURN_Q = TURN << FRAC_BITS;
  localparam int HALF_Q = HALF_TURN << FRAC_BITS;
  localparam int HEAD_W = $clog2(TURN_Q);

  // Delta datapath: difference of two readings, unwrapped magnitude, gain product
  localparam int DIFF_W = SAMPLE_W + 2;
  localparam int DMAG_W = SAMPLE_W;
  localparam int PROD_W = DMAG_W + GAIN_W;

  // Q.12 to Q.FRAC_BITS conversion
  localparam int RND_SH   = (FRAC_BITS < 12) ? 12 - FRAC_BITS : 0;
  localparam int LFT_SH   = (FRAC_BITS > 12) ? FRAC_BITS - 12 : 0;
  localparam int RND_HALF = (1 << RND_SH) >> 1;
  localparam int MAG_W    = PROD_W - RND_SH + LFT_SH;

  // Reciprocal of one turn for the quotient estimate
  localparam int Q_W      = MAG_W - HEAD_W + 1;
  localparam int RECIP_SH = MAG_W + 2;
  localparam int RECIP_W  = RECIP_SH - HEAD_W + 2;
  localparam longint unsigned RECIP_K = (64'd1 << RECIP_SH) / TURN_Q;

  // Function codes of the input transaction
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_A_CCW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_CW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_CCW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_CW  = 2'd3;

  // Operation carried down the pipeline
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_TRACK,
    OP_SET,
    OP_CLEAR
  } op_t;

  // Scaled delta of one channel
  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic              neg;
  } scaled_t;

endpackage

@@ hdl/dght_stream_ifs.sv @@
// Interfaces: input and result channels of the heading tracker
interface dght_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [dght_pkg::FUNC_W-1:0]          func;
  logic signed [dght_pkg::SAMPLE_W-1:0] sample_a;
  logic signed [dght_pkg::SAMPLE_W-1:0] sample_b;
  logic [dght_pkg::NH_W-1:0]            new_heading;

  modport source (output valid, func, sample_a, sample_b, new_heading, input ready);
  modport sink   (input valid, func, sample_a, sample_b, new_heading, output ready);
endinterface

interface dght_out_if;
  logic                       valid;
  logic                       ready;
  logic [dght_pkg::OUT_W-1:0] heading_avg;
  logic [dght_pkg::OUT_W-1:0] heading_chan_a;
  logic [dght_pkg::OUT_W-1:0] heading_chan_b;

  modport source (output valid, heading_avg, heading_chan_a, heading_chan_b, input ready);
  modport sink   (input valid, heading_avg, heading_chan_a, heading_chan_b, output ready);
endinterface

@@ hdl/dual_gyro_heading_tracker_unit.sv @@
// Top level: dual gyro heading tracker, six-register pipeline with back-pressure
// Path: input register, stages 1 to 3, heading register, then result register.
// Throughput: one transaction per cycle unless the sink holds off; the gain
// multiply, the turn quotient multiply and the heading add each sit in a stage of their own.
// Reset: synchronous active-low rst_n empties the pipeline, zeroes headings,
// previous readings and the primed flag, and loads all gains with 1.0 (Q4.12).
`include "assert_macros.svh"

module dual_gyro_heading_tracker_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  dght_in_if.sink                           in_ch,
  dght_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [dght_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dght_pkg::GAIN_W-1:0]       cfg_wdata
);

  localparam int HW = dght_pkg::HEAD_W;
  localparam logic [HW-1:0] TURN_H = HW'(dght_pkg::TURN_Q);
  localparam logic [dght_pkg::NH_W-1:0] TURN_NH = dght_pkg::NH_W'(dght_pkg::TURN);

  // Gain registers
  logic [dght_pkg::GAIN_W-1:0] a_ccw_r, a_cw_r, b_ccw_r, b_cw_r;

  // Input register
  logic                                 v0_r;
  logic [dght_pkg::FUNC_W-1:0]          func0_r;
  logic signed [dght_pkg::SAMPLE_W-1:0] sa0_r, sb0_r;
  logic [dght_pkg::NH_W-1:0]            nh0_r;

  // Reading state
  logic signed [dght_pkg::SAMPLE_W-1:0] prev_a_r, prev_b_r, prev_a_nxt, prev_b_nxt;
  logic                                 primed_r, primed_nxt;

  // Pipeline stages
  logic                       v1_r, v2_r, v3_r, vh_r, vo_r;
  dght_pkg::op_t              op1_nxt, op1_r, op2_r, op3_r;
  logic [dght_pkg::NH_W-1:0]  nh1_nxt, nh1_r, nh2_r, nh3_r;
  dght_pkg::scaled_t          sc_a, sc_b, sc_a1_r, sc_b1_r;
  logic [dght_pkg::MAG_W-1:0] mag_a, mag_b, mag_a2_r, mag_b2_r;
  logic [dght_pkg::Q_W-1:0]   q_a, q_b, q_a2_r, q_b2_r;
  logic                       neg_a2_r, neg_b2_r, neg_a3_r, neg_b3_r;
  logic [HW-1:0]              res_a, res_b, res_a3_r, res_b3_r;

  // Heading state and result register
  logic [HW-1:0]              heading_a_r, heading_b_r, heading_a_nxt, heading_b_nxt;
  logic [HW-1:0]              avg;
  logic [dght_pkg::OUT_W-1:0] avg_o_r, ha_o_r, hb_o_r;

  // Stage handshake
  logic rdy0, rdy1, rdy2, rdy3, rdyh, rdyo;
  logic adv0, adv1, adv2, adv3, advh;

  // Advance a stage when the next one is empty or advancing
  always_comb begin
    rdyo = !vo_r || out_ch.ready;
    rdyh = !vh_r || rdyo;
    rdy3 = !v3_r || rdyh;
    rdy2 = !v2_r || rdy3;
    rdy1 = !v1_r || rdy2;
    rdy0 = !v0_r || rdy1;
    adv0 = v0_r && rdy1;
    adv1 = v1_r && rdy2;
    adv2 = v2_r && rdy3;
    adv3 = v3_r && rdyh;
    advh = vh_r && rdyo;
  end

  assign in_ch.ready           = rdy0;
  assign out_ch.valid          = vo_r;
  assign out_ch.heading_avg    = avg_o_r;
  assign out_ch.heading_chan_a = ha_o_r;
  assign out_ch.heading_chan_b = hb_o_r;

  // Gain register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ccw_r <= dght_pkg::GAIN_RESET;
      a_cw_r  <= dght_pkg::GAIN_RESET;
      b_ccw_r <= dght_pkg::GAIN_RESET;
      b_cw_r  <= dght_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dght_pkg::CFG_A_CCW: a_ccw_r <= cfg_wdata;
        dght_pkg::CFG_A_CW:  a_cw_r  <= cfg_wdata;
        dght_pkg::CFG_B_CCW: b_ccw_r <= cfg_wdata;
        dght_pkg::CFG_B_CW:  b_cw_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy0) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_ch.valid) begin
      func0_r <= in_ch.func;
      sa0_r   <= in_ch.sample_a;
      sb0_r   <= in_ch.sample_b;
      nh0_r   <= in_ch.new_heading;
    end
  end

  // Decode the operation and update the reading state
  always_comb begin
    prev_a_nxt = prev_a_r;
    prev_b_nxt = prev_b_r;
    primed_nxt = primed_r;
    case (func0_r)
      dght_pkg::FUNC_TICK: begin
        op1_nxt    = primed_r ? dght_pkg::OP_TRACK : dght_pkg::OP_HOLD;
        prev_a_nxt = sa0_r;
        prev_b_nxt = sb0_r;
        primed_nxt = 1'b1;
      end
      dght_pkg::FUNC_SET: begin
        op1_nxt = dght_pkg::OP_SET;
      end
      dght_pkg::FUNC_CLEAR: begin
        op1_nxt    = dght_pkg::OP_CLEAR;
        prev_a_nxt = '0;
        prev_b_nxt = '0;
      end
      default: begin
        op1_nxt = dght_pkg::OP_HOLD;
      end
    endcase
    nh1_nxt = (nh0_r >= TURN_NH) ? nh0_r - TURN_NH : nh0_r;
  end

  dght_delta_scale u_delta_a (
    .prev     (prev_a_r),
    .sample   (sa0_r),
    .ccw_gain (a_ccw_r),
    .cw_gain  (a_cw_r),
    .scaled   (sc_a)
  );

  dght_delta_scale u_delta_b (
    .prev     (prev_b_r),
    .sample   (sb0_r),
    .ccw_gain (b_ccw_r),
    .cw_gain  (b_cw_r),
    .scaled   (sc_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r <= '0;
      prev_b_r <= '0;
      primed_r <= 1'b0;
    end else if (adv0) begin
      prev_a_r <= prev_a_nxt;
      prev_b_r <= prev_b_nxt;
      primed_r <= primed_nxt;
    end
  end

  // Stage 1: scaled products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0) begin
      op1_r   <= op1_nxt;
      nh1_r   <= nh1_nxt;
      sc_a1_r <= sc_a;
      sc_b1_r <= sc_b;
    end
  end

  dght_round_recip u_round_a (.prod (sc_a1_r.prod), .mag (mag_a), .quot (q_a));
  dght_round_recip u_round_b (.prod (sc_b1_r.prod), .mag (mag_b), .quot (q_b));

  // Stage 2: rounded magnitudes and turn estimates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      op2_r    <= op1_r;
      nh2_r    <= nh1_r;
      mag_a2_r <= mag_a;
      mag_b2_r <= mag_b;
      q_a2_r   <= q_a;
      q_b2_r   <= q_b;
      neg_a2_r <= sc_a1_r.neg;
      neg_b2_r <= sc_b1_r.neg;
    end
  end

  dght_mod_fix u_mod_a (.mag (mag_a2_r), .quot (q_a2_r), .residue (res_a));
  dght_mod_fix u_mod_b (.mag (mag_b2_r), .quot (q_b2_r), .residue (res_b));

  // Stage 3: residues within one turn
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      op3_r    <= op2_r;
      nh3_r    <= nh2_r;
      res_a3_r <= res_a;
      res_b3_r <= res_b;
      neg_a3_r <= neg_a2_r;
      neg_b3_r <= neg_b2_r;
    end
  end

  // Add or subtract a residue modulo one turn
  function automatic logic [HW-1:0] head_step(input logic [HW-1:0] head,
                                              input logic [HW-1:0] res,
                                              input logic          neg);
    logic [HW:0] t;
    if (neg) begin
      t = {1'b0, head} - {1'b0, res};
      if (t[HW]) begin
        t = t + {1'b0, TURN_H};
      end
    end else begin
      t = {1'b0, head} + {1'b0, res};
      if (t >= {1'b0, TURN_H}) begin
        t = t - {1'b0, TURN_H};
      end
    end
    return HW'(t);
  endfunction

  // Stage 4: apply the operation to the headings
  always_comb begin
    case (op3_r)
      dght_pkg::OP_TRACK: begin
        heading_a_nxt = head_step(heading_a_r, res_a3_r, neg_a3_r);
        heading_b_nxt = head_step(heading_b_r, res_b3_r, neg_b3_r);
      end
      dght_pkg::OP_SET: begin
        heading_a_nxt = HW'(nh3_r) << dght_pkg::FRAC_BITS;
        heading_b_nxt = HW'(nh3_r) << dght_pkg::FRAC_BITS;
      end
      dght_pkg::OP_CLEAR: begin
        heading_a_nxt = '0;
        heading_b_nxt = '0;
      end
      default: begin
        heading_a_nxt = heading_a_r;
        heading_b_nxt = heading_b_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vh_r        <= 1'b0;
      heading_a_r <= '0;
      heading_b_r <= '0;
    end else begin
      if (rdyh) begin
        vh_r <= v3_r;
      end
      if (adv3) begin
        heading_a_r <= heading_a_nxt;
        heading_b_r <= heading_b_nxt;
      end
    end
  end

  dght_heading_avg u_avg (.head_a (heading_a_r), .head_b (heading_b_r), .avg (avg));

  // Result register: hold until the sink takes the transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (rdyo) begin
      vo_r <= vh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advh) begin
      avg_o_r <= dght_pkg::OUT_W'(avg);
      ha_o_r  <= dght_pkg::OUT_W'(heading_a_r);
      hb_o_r  <= dght_pkg::OUT_W'(heading_b_r);
    end
  end

  // Headings stay inside one turn after every update
  `ASSERT_NEXT(a_heading_range, clk, rst_n, adv3, (heading_a_r < TURN_H) && (heading_b_r < TURN_H))
  // Residues leaving the reduction are within one turn
  `ASSERT_IMPL(a_residue_range, clk, rst_n, v3_r, (res_a3_r < TURN_H) && (res_b3_r < TURN_H))
  // Input stalls only when every stage is full and the sink holds off
  `ASSERT_IMPL(a_stall_full, clk, rst_n, !in_ch.ready, v0_r && v1_r && v2_r && v3_r && vh_r && vo_r && !out_ch.ready)
  // Once primed, the tracker stays primed
  `ASSERT_NEXT(a_primed_sticky, clk, rst_n, primed_r, primed_r)

endmodule

@@ hdl/dght_delta_scale.sv @@
// Delta stage: negated change of one reading, turn unwrap and gain multiply
module dght_delta_scale (
  input  logic signed [dght_pkg::SAMPLE_W-1:0] prev,
  input  logic signed [dght_pkg::SAMPLE_W-1:0] sample,
  input  logic [dght_pkg::GAIN_W-1:0]          ccw_gain,
  input  logic [dght_pkg::GAIN_W-1:0]          cw_gain,
  output dght_pkg::scaled_t                    scaled
);

  localparam int DW = dght_pkg::DIFF_W;
  localparam logic signed [DW-1:0] WRAP_S = DW'(dght_pkg::WRAP_LIMIT);
  localparam logic signed [DW-1:0] TURN_S = DW'(dght_pkg::TURN);

  logic signed [DW-1:0]             diff;
  logic signed [DW-1:0]             delta;
  logic signed [DW-1:0]             abs_delta;
  logic [dght_pkg::DMAG_W-1:0]      mag;
  logic [dght_pkg::GAIN_W-1:0]      gain;

  // Negate the change, unwrap one turn towards zero
  always_comb begin
    diff = DW'(prev) - DW'(sample);
    if (diff > WRAP_S) begin
      delta = diff - TURN_S;
    end else if (diff < -WRAP_S) begin
      delta = diff + TURN_S;
    end else begin
      delta = diff;
    end
  end

  // Pick the gain by direction and scale the magnitude
  always_comb begin
    abs_delta   = delta[DW-1] ? -delta : delta;
    mag         = dght_pkg::DMAG_W'(abs_delta);
    gain        = (!delta[DW-1] && (delta != '0)) ? ccw_gain : cw_gain;
    scaled.neg  = delta[DW-1];
    scaled.prod = dght_pkg::PROD_W'(mag) * dght_pkg::PROD_W'(gain);
  end

endmodule

@@ hdl/dght_round_recip.sv @@
// Round stage: Q.12 product to heading format and quotient estimate by one turn
module dght_round_recip (
  input  logic [dght_pkg::PROD_W-1:0] prod,
  output logic [dght_pkg::MAG_W-1:0]  mag,
  output logic [dght_pkg::Q_W-1:0]    quot
);

  localparam int WORK_W = dght_pkg::PROD_W + 1 + dght_pkg::LFT_SH;
  localparam int RP_W   = dght_pkg::MAG_W + dght_pkg::RECIP_W;

  logic [WORK_W-1:0] rounded;
  logic [RP_W-1:0]   recip_prod;

  // Round to nearest on the magnitude, then align to the fraction bits
  always_comb begin
    rounded = WORK_W'(prod) + WORK_W'(dght_pkg::RND_HALF);
    mag     = dght_pkg::MAG_W'((rounded >> dght_pkg::RND_SH) << dght_pkg::LFT_SH);
  end

  // Estimate the turn count; it is exact or one low
  always_comb begin
    recip_prod = RP_W'(mag) * RP_W'(dght_pkg::RECIP_K);
    quot       = dght_pkg::Q_W'(recip_prod >> dght_pkg::RECIP_SH);
  end

endmodule

@@ hdl/dght_mod_fix.sv @@
// Residue stage: remove whole turns from the scaled magnitude
module dght_mod_fix (
  input  logic [dght_pkg::MAG_W-1:0]  mag,
  input  logic [dght_pkg::Q_W-1:0]    quot,
  output logic [dght_pkg::HEAD_W-1:0] residue
);

  localparam int HW = dght_pkg::HEAD_W;
  localparam logic [HW:0] TURN_R = (HW+1)'(dght_pkg::TURN_Q);

  logic [dght_pkg::MAG_W-1:0] whole;
  logic [dght_pkg::MAG_W-1:0] rem_w;
  logic [HW:0]                rem0;

  // Subtract the estimated turns, then correct once
  always_comb begin
    whole = dght_pkg::MAG_W'(quot) * dght_pkg::MAG_W'(dght_pkg::TURN_Q);
    rem_w = mag - whole;
    rem0  = (HW+1)'(rem_w);
    if (rem0 >= TURN_R) begin
      residue = HW'(rem0 - TURN_R);
    end else begin
      residue = HW'(rem0);
    end
  end

endmodule

@@ hdl/dght_heading_avg.sv @@
// Average stage: wrap-aware mean of the two channel headings
module dght_heading_avg (
  input  logic [dght_pkg::HEAD_W-1:0] head_a,
  input  logic [dght_pkg::HEAD_W-1:0] head_b,
  output logic [dght_pkg::HEAD_W-1:0] avg
);

  localparam int HW = dght_pkg::HEAD_W;
  localparam int SW = dght_pkg::HEAD_W + 2;
  localparam logic [HW-1:0]        HALF_H  = HW'(dght_pkg::HALF_Q);
  localparam logic signed [SW-1:0] TURN_S  = SW'(dght_pkg::TURN_Q);
  localparam logic signed [SW-1:0] TURN2_S = SW'(2 * dght_pkg::TURN_Q);

  logic [HW-1:0]        lo;
  logic [HW-1:0]        hi;
  logic signed [SW-1:0] hi_s;
  logic signed [SW-1:0] lo_s;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] sum_pos;

  // Order the pair and pull the larger one down a turn across the seam
  always_comb begin
    lo   = (head_a < head_b) ? head_a : head_b;
    hi   = (head_a < head_b) ? head_b : head_a;
    hi_s = $signed({2'b00, hi});
    lo_s = $signed({2'b00, lo});
    if ((hi - lo) > HALF_H) begin
      sum = hi_s - TURN_S + lo_s;
    end else begin
      sum = hi_s + lo_s;
    end
    sum_pos = (sum < 0) ? sum + TURN2_S : sum;
    avg     = HW'(sum_pos >>> 1);
  end

endmodule
